[rtl/sdtq_pkg.sv]
// Package for the sorted deadline timer queue: sizes, codes, payload and cell types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sdtq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TOKEN_BITS  = 16;
    localparam int TIME_W      = 48;
    localparam int FTOK_W      = 16;

    localparam logic [1:0] MODE_ABS   = 2'd0;
    localparam logic [1:0] MODE_OFS   = 2'd1;
    localparam logic [1:0] MODE_CHECK = 2'd2;

    localparam logic KIND_FIRED  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [1:0]        mode;
        logic [TIME_W-1:0] time_value;
        logic [FTOK_W-1:0] event_token;
        logic [TIME_W-1:0] now_time;
    } in_item_t;

    typedef struct packed {
        logic              kind;
        logic [FTOK_W-1:0] fired_token;
        logic              last;
        logic              rearm_valid;
        logic [TIME_W-1:0] rearm_delay;
        logic              dropped;
    } out_item_t;

    typedef struct packed {
        logic                  valid;
        logic [TIME_W-1:0]     deadline;
        logic [TOKEN_BITS-1:0] token;
    } entry_t;

    typedef struct packed {
        logic                  insert;
        logic                  pop;
        logic [TIME_W-1:0]     when;
        logic [TOKEN_BITS-1:0] token;
    } cell_cmd_t;

    function automatic logic [TOKEN_BITS-1:0] tok_in(input logic [FTOK_W-1:0] t);
        logic [TOKEN_BITS+FTOK_W-1:0] w;
        w = {{TOKEN_BITS{1'b0}}, t};
        return w[TOKEN_BITS-1:0];
    endfunction

    function automatic logic [FTOK_W-1:0] tok_out(input logic [TOKEN_BITS-1:0] t);
        logic [TOKEN_BITS+FTOK_W-1:0] w;
        w = {{FTOK_W{1'b0}}, t};
        return w[FTOK_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/sorted_deadline_timer_queue_unit.sv]
// Sorted deadline timer queue: accept, time prep, insert, then one fired beat per expired
// alarm and a closing status beat for each item.
// Issue rate: the chain pops one alarm per cycle to the output register when it is free.
// Reset (rst_n low, asynchronous) empties the chain and clears the origin to zero.
// A new item is taken while the previous status beat still waits at the output.
// Depends on sdtq_pkg and sdtq_chain.
`timescale 1ns / 1ps
`default_nettype none

module sorted_deadline_timer_queue_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire sdtq_pkg::in_item_t           in_item,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output sdtq_pkg::out_item_t               out_item,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [sdtq_pkg::TIME_W-1:0]  cfg_data
);
    import sdtq_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_PREP   = 4'b0010,
        ST_INSERT = 4'b0100,
        ST_FIRE   = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [TIME_W-1:0]     origin_reg;
    logic [1:0]            mode_reg;
    logic [TIME_W-1:0]     tval_reg;
    logic [TOKEN_BITS-1:0] tok_reg;
    logic [TIME_W-1:0]     now_reg;
    logic [TIME_W-1:0]     when_reg, when_next;
    logic                  new_head_reg, new_head_next;
    logic                  dropped_reg, dropped_next;
    logic                  fired_any_reg, fired_any_next;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_reg, out_next;

    cell_cmd_t             cmd;
    entry_t                head;
    logic                  head_le;
    logic                  full;
    logic                  is_post;
    logic                  out_free;
    logic                  expire;
    logic                  rearm;
    logic [TIME_W:0]       ofs_sum;
    logic [TIME_W-1:0]     now_rel;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    assign is_post  = (mode_reg == MODE_ABS) || (mode_reg == MODE_OFS);
    assign out_free = !out_valid_reg || out_ready;
    assign expire   = head.valid && (head.deadline <= now_reg);
    assign rearm    = head.valid && (fired_any_reg || new_head_reg);
    assign ofs_sum  = {1'b0, now_reg} + {1'b0, tval_reg};
    assign now_rel  = (in_item.now_time >= origin_reg) ? in_item.now_time - origin_reg : '0;

    assign cmd = '{insert: (state_reg == ST_INSERT) && is_post && !full,
                   pop:    (state_reg == ST_FIRE) && out_free && expire,
                   when:   when_reg,
                   token:  tok_reg};

    sdtq_chain u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .head    (head),
        .head_le (head_le),
        .full    (full)
    );

    always_comb
    begin
        state_next     = state_reg;
        when_next      = when_reg;
        new_head_next  = new_head_reg;
        dropped_next   = dropped_reg;
        fired_any_next = fired_any_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                if (mode_reg == MODE_ABS)
                    when_next = (tval_reg >= origin_reg) ? tval_reg - origin_reg : '0;
                else
                    when_next = ofs_sum[TIME_W] ? {TIME_W{1'b1}} : ofs_sum[TIME_W-1:0];
                state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                new_head_next  = cmd.insert && !head_le;
                dropped_next   = is_post && full;
                fired_any_next = 1'b0;
                state_next     = ST_FIRE;
            end
            ST_FIRE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (expire)
                    begin
                        fired_any_next = 1'b1;
                        out_next = '{kind: KIND_FIRED, fired_token: tok_out(head.token),
                                     last: 1'b0, rearm_valid: 1'b0, rearm_delay: '0,
                                     dropped: 1'b0};
                    end
                    else
                    begin
                        out_next = '{kind: KIND_STATUS, fired_token: '0, last: 1'b1,
                                     rearm_valid: rearm,
                                     rearm_delay: rearm ? head.deadline - now_reg : '0,
                                     dropped: dropped_reg};
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            origin_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
                origin_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg <= in_item.mode;
            tval_reg <= in_item.time_value;
            tok_reg  <= tok_in(in_item.event_token);
            now_reg  <= now_rel;
        end
        when_reg      <= when_next;
        new_head_reg  <= new_head_next;
        dropped_reg   <= dropped_next;
        fired_any_reg <= fired_any_next;
        out_reg       <= out_next;
    end

`ifndef ASSERT_OFF
    a_pop_expired: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> head.valid && (head.deadline <= now_reg))
        else $error("pop of an alarm that has not expired");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> !full)
        else $error("insert into a full chain");

    a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_PREP))
        else $error("accepted item did not enter prep");

    a_fired_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_item.kind == KIND_FIRED)) |->
        (!out_item.last && !out_item.rearm_valid && !out_item.dropped))
        else $error("fired beat carries status fields");
`endif

endmodule

`default_nettype wire

[rtl/sdtq_cell.sv]
// One slot of the sorted alarm chain: holds an entry, inserts in order, shifts on pop.
// Depends on sdtq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdtq_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sdtq_pkg::cell_cmd_t cmd,
    input  wire sdtq_pkg::entry_t   left,
    input  wire logic               left_le,
    input  wire sdtq_pkg::entry_t   right,
    output sdtq_pkg::entry_t        ent,
    output logic                    le
);
    import sdtq_pkg::*;

    logic                  valid_reg;
    logic [TIME_W-1:0]     deadline_reg;
    logic [TOKEN_BITS-1:0] token_reg;
    entry_t                ent_next;

    assign ent = '{valid: valid_reg, deadline: deadline_reg, token: token_reg};
    assign le  = valid_reg && (deadline_reg <= cmd.when);

    always_comb
    begin
        ent_next = ent;
        priority if (cmd.insert)
        begin
            if (!left_le)
                ent_next = left;
            else if (!le)
                ent_next = '{valid: 1'b1, deadline: cmd.when, token: cmd.token};
        end
        else if (cmd.pop)
        begin
            ent_next = right;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= ent_next.valid;
    end

    always_ff @(posedge clk)
    begin
        deadline_reg <= ent_next.deadline;
        token_reg    <= ent_next.token;
    end

endmodule

`default_nettype wire

[rtl/sdtq_chain.sv]
// Row of QUEUE_DEPTH cells kept sorted by deadline, earliest at the head.
// Depends on sdtq_pkg and sdtq_cell.
`timescale 1ns / 1ps
`default_nettype none

module sdtq_chain (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sdtq_pkg::cell_cmd_t cmd,
    output sdtq_pkg::entry_t        head,
    output logic                    head_le,
    output logic                    full
);
    import sdtq_pkg::*;

    entry_t ents [QUEUE_DEPTH];
    logic   les  [QUEUE_DEPTH];

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        entry_t left_e;
        entry_t right_e;
        logic   left_le_w;

        if (i == 0)
        begin : g_first
            assign left_e    = '0;
            assign left_le_w = 1'b1;
        end
        else
        begin : g_mid
            assign left_e    = ents[i-1];
            assign left_le_w = les[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_e = '0;
        end
        else
        begin : g_inner
            assign right_e = ents[i+1];
        end

        sdtq_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .left    (left_e),
            .left_le (left_le_w),
            .right   (right_e),
            .ent     (ents[i]),
            .le      (les[i])
        );
    end

    assign head    = ents[0];
    assign head_le = les[0];
    assign full    = ents[QUEUE_DEPTH-1].valid;

endmodule

`default_nettype wire

[tb/tb_sorted_deadline_timer_queue_unit.sv]
// Testbench for sorted_deadline_timer_queue_unit: a directed run, then four random phases
// with different time origins and idling. An alarm-table model predicts every result beat.
// Depends on sdtq_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_sorted_deadline_timer_queue_unit;
    import sdtq_pkg::*;

    localparam logic [1:0]        MODE_SPARE  = 2'd3;
    localparam int                CYCLE_LIMIT = 600000;
    localparam logic [TIME_W-1:0] TIME_MAX    = '1;

    class alarm_table_model;
        logic [TIME_W-1:0] origin;
        logic [TIME_W-1:0] deadlines[QUEUE_DEPTH];
        logic [FTOK_W-1:0] tokens[QUEUE_DEPTH];
        int                fill;
        logic [TIME_W-1:0] earliest;
        out_item_t         awaited[$];
        int unsigned       errors;
        int unsigned       items_seen;
        int unsigned       fired_seen;
        int unsigned       status_seen;
        int unsigned       drops_seen;

        function new();
            origin      = '0;
            fill        = 0;
            earliest    = '0;
            errors      = 0;
            items_seen  = 0;
            fired_seen  = 0;
            status_seen = 0;
            drops_seen  = 0;
        endfunction

        function void set_origin(input logic [TIME_W-1:0] value);
            origin = value;
        endfunction

        function logic [TIME_W-1:0] since_origin(input logic [TIME_W-1:0] t);
            return (t >= origin) ? t - origin : '0;
        endfunction

        // accepted input beat: update the table and queue the beats it causes
        function void post_item(input in_item_t it);
            logic [TIME_W-1:0] now;
            logic [TIME_W-1:0] when;
            logic [TIME_W:0]   sum;
            logic              rearm;
            logic              dropped;
            logic              was_empty;
            int                pos;
            int                n_fire;
            int                i;
            out_item_t         r;
            now     = since_origin(it.now_time);
            rearm   = 1'b0;
            dropped = 1'b0;
            n_fire  = 0;
            items_seen++;
            if (it.mode == MODE_ABS || it.mode == MODE_OFS)
            begin
                was_empty = (fill == 0);
                if (it.mode == MODE_ABS)
                begin
                    when = since_origin(it.time_value);
                end
                else
                begin
                    sum  = {1'b0, now} + {1'b0, it.time_value};
                    when = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                end
                if (fill >= QUEUE_DEPTH)
                begin
                    dropped = 1'b1;
                end
                else
                begin
                    pos = 0;
                    while (pos < fill && deadlines[pos] <= when)
                        pos++;
                    for (i = fill; i > pos; i--)
                    begin
                        deadlines[i] = deadlines[i-1];
                        tokens[i]    = tokens[i-1];
                    end
                    deadlines[pos] = when;
                    tokens[pos]    = it.event_token;
                    fill++;
                    if (was_empty || when < earliest)
                    begin
                        earliest = when;
                        rearm    = 1'b1;
                    end
                end
            end
            if (now >= earliest)
            begin
                while (n_fire < fill && deadlines[n_fire] <= now)
                begin
                    r             = '0;
                    r.kind        = KIND_FIRED;
                    r.fired_token = tokens[n_fire];
                    awaited.push_back(r);
                    n_fire++;
                end
                for (i = n_fire; i < fill; i++)
                begin
                    deadlines[i-n_fire] = deadlines[i];
                    tokens[i-n_fire]    = tokens[i];
                end
                fill -= n_fire;
                if (fill > 0)
                begin
                    earliest = deadlines[0];
                    rearm    = 1'b1;
                end
                else
                begin
                    earliest = '0;
                    rearm    = 1'b0;
                end
            end
            r             = '0;
            r.kind        = KIND_STATUS;
            r.last        = 1'b1;
            r.rearm_valid = rearm;
            r.rearm_delay = (rearm && earliest > now) ? earliest - now : '0;
            r.dropped     = dropped;
            awaited.push_back(r);
        endfunction

        // accepted result beat: compare with the oldest expectation
        function void take_beat(input out_item_t got);
            out_item_t want;
            logic      bad;
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR %0t: unexpected beat kind=%0d tok=%h", $realtime,
                             got.kind, got.fired_token);
                return;
            end
            want = awaited.pop_front();
            if (want.kind == KIND_STATUS)
                status_seen++;
            else
                fired_seen++;
            if (want.dropped)
                drops_seen++;
            bad = (got.kind !== want.kind) || (got.fired_token !== want.fired_token)
                || (got.last !== want.last) || (got.rearm_valid !== want.rearm_valid)
                || (got.rearm_delay !== want.rearm_delay) || (got.dropped !== want.dropped);
            if (bad)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("ERROR %0t: expected kind=%0d tok=%h last=%0d rearm=%0d %s%0d drop=%0d",
                             $realtime, want.kind, want.fired_token, want.last,
                             want.rearm_valid, "delay=", want.rearm_delay, want.dropped);
                    $display("             got kind=%0d tok=%h last=%0d rearm=%0d %s%0d drop=%0d",
                             got.kind, got.fired_token, got.last, got.rearm_valid,
                             "delay=", got.rearm_delay, got.dropped);
                end
            end
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    in_item_t          in_item   = '0;
    logic              out_ready = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [TIME_W-1:0] cfg_data  = '0;
    logic              in_ready;
    logic              out_valid;
    logic              cfg_ready;
    out_item_t         out_item;

    alarm_table_model  model = new();
    int unsigned       send_idle_pct  = 0;
    int unsigned       take_stall_pct = 0;
    longint            cycles         = 0;
    logic [TIME_W-1:0] wall_time      = '0;

    sorted_deadline_timer_queue_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            model.take_beat(out_item);
        out_ready <= ($urandom_range(0, 99) >= take_stall_pct);
    end

    function automatic logic [TIME_W-1:0] rand_time();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[TIME_W-1:0];
    endfunction

    task automatic send_item(input in_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        model.post_item(it);
    endtask

    task automatic send_fields(input logic [1:0] mode, input logic [TIME_W-1:0] tv,
                               input logic [FTOK_W-1:0] tok, input logic [TIME_W-1:0] now);
        in_item_t it;
        it.mode        = mode;
        it.time_value  = tv;
        it.event_token = tok;
        it.now_time    = now;
        send_item(it);
    endtask

    task automatic drain_then_idle(input int settle);
        in_valid <= 1'b0;
        while (model.awaited.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_origin(input logic [TIME_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        model.set_origin(value);
    endtask

    task automatic directed_sequence();
        int i;
        send_fields(MODE_CHECK, '0, '0, '0);
        send_fields(MODE_SPARE, TIME_MAX, 16'hFFFF, 48'd5);
        send_fields(MODE_ABS, '0, 16'hFFFF, '0);
        send_fields(MODE_OFS, TIME_MAX, 16'h0001, 48'd10);
        send_fields(MODE_ABS, 48'd1000, 16'hA5A5, 48'd500);
        send_fields(MODE_CHECK, 48'd77, 16'h5A5A, 48'd1000);
        // equal deadlines leave in arrival order
        send_fields(MODE_ABS, 48'd2000, 16'h0011, 48'd1500);
        send_fields(MODE_ABS, 48'd2000, 16'h0022, 48'd1500);
        send_fields(MODE_OFS, 48'd500, 16'h0033, 48'd1500);
        send_fields(MODE_CHECK, '0, '0, 48'd2000);
        // fill the table, overflow it, then fire everything at once
        for (i = 0; i < QUEUE_DEPTH - 1; i++)
            send_fields(MODE_ABS, 48'(10000 - 100 * i), 16'($urandom), 48'd2000);
        send_fields(MODE_ABS, 48'd3000, 16'hBEEF, 48'd2000);
        send_fields(MODE_CHECK, '0, '0, TIME_MAX);
    endtask

    task automatic run_phase(input logic [TIME_W-1:0] base, input int unsigned idle,
                             input int unsigned stall, input int count);
        in_item_t    it;
        int unsigned pick;
        int          n;
        drain_then_idle(8);
        write_origin(base);
        send_idle_pct  = idle;
        take_stall_pct = stall;
        wall_time      = base + $urandom_range(0, 1000);
        for (n = 0; n < count; n++)
        begin
            if (n == count / 2)
                drain_then_idle(8);
            it.mode        = 2'($urandom_range(0, 3));
            it.time_value  = rand_time();
            it.event_token = 16'($urandom);
            it.now_time    = rand_time();
            pick = $urandom_range(0, 99);
            if (pick >= 10)
            begin
                wall_time   = wall_time + $urandom_range(0, 150);
                it.now_time = wall_time;
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    it.mode = MODE_ABS;
                    if ($urandom_range(0, 9) == 0)
                        it.time_value = base - $urandom_range(0, 2000);
                    else
                        it.time_value = wall_time + $urandom_range(0, 800);
                end
                else if (pick < 80)
                begin
                    it.mode = MODE_OFS;
                    if ($urandom_range(0, 9) == 0)
                        it.time_value = TIME_MAX - $urandom_range(0, 5000);
                    else
                        it.time_value = 48'($urandom_range(0, 800));
                end
                else if (pick < 95)
                begin
                    it.mode = MODE_CHECK;
                end
                else
                begin
                    it.mode = MODE_SPARE;
                end
            end
            send_item(it);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_sequence();
        run_phase(rand_time() >> 1, 0, 0, 24);
        run_phase('0, 81, 0, 24);
        run_phase(TIME_MAX, 0, 81, 24);
        run_phase(48'($urandom_range(1, 100000)), 18, 18, 24);
        drain_then_idle(40);
        $display("Run: %0d items over five time origins, %0d alarms fired, %0d status beats.",
                 model.items_seen, model.fired_seen, model.status_seen);
        $display("     %0d posts refused on a full table, %0d mismatches.",
                 model.drops_seen, model.errors);
        if (model.errors == 0 && model.awaited.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/sdtq_pkg.sv
rtl/sdtq_cell.sv
rtl/sdtq_chain.sv
rtl/sorted_deadline_timer_queue_unit.sv
tb/tb_sorted_deadline_timer_queue_unit.sv
